### hw/rtl/oriented_quad_vertices_defines.svh
// ---------------------------------------------------------------------------
// oriented_quad_vertices_defines: assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef ORIENTED_QUAD_VERTICES_DEFINES_SVH
`define ORIENTED_QUAD_VERTICES_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define OQV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("oqv assertion failed");
// next-cycle implication
`define OQV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("oqv assertion failed");
`else
`define OQV_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define OQV_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/oqv_pkg.sv
// ---------------------------------------------------------------------------
// oqv_pkg: shared types and constants
// payload structs, widths and register indexes of the quad corner pipeline
// ---------------------------------------------------------------------------
package oqv_pkg;

   localparam int CW          = 32;  // coordinate width
   localparam int RAD_W       = CW - 1;
   localparam int RATIO_W     = 16;
   localparam int CS          = 30;  // fraction bits of direction cosines
   localparam int NRM_W       = 31;  // normalized magnitude width
   localparam int ROOT_W      = 32;
   localparam int QUO_W       = 31;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] REG_HALF_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_WIDTH  = 1'd1;

   localparam logic [RATIO_W-1:0] HALF_LENGTH_RESET = 16'd58982;
   localparam logic [RATIO_W-1:0] HALF_WIDTH_RESET  = 16'd6554;

   localparam int NORM_STAGES   = 5;
   localparam int SQRT_STAGES   = ROOT_W + 1;
   localparam int DIV_STAGES    = QUO_W + 2;
   localparam int CORNER_STAGES = 4;
   localparam int LATENCY = NORM_STAGES + SQRT_STAGES + DIV_STAGES + CORNER_STAGES;

   typedef struct packed {
      logic signed [CW-1:0] vel_x;
      logic signed [CW-1:0] vel_y;
      logic signed [CW-1:0] pos_x;
      logic signed [CW-1:0] pos_y;
      logic [RAD_W-1:0]     radius;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] front_left_x;
      logic signed [CW-1:0] front_left_y;
      logic signed [CW-1:0] front_right_x;
      logic signed [CW-1:0] front_right_y;
      logic signed [CW-1:0] back_right_x;
      logic signed [CW-1:0] back_right_y;
      logic signed [CW-1:0] back_left_x;
      logic signed [CW-1:0] back_left_y;
   } rsp_type;

   // values that ride along the root and divide stages
   typedef struct packed {
      logic                 neg_vx;
      logic                 pos_vy;
      logic                 zero;
      logic [RAD_W-1:0]     hl;
      logic [RAD_W-1:0]     hw;
      logic signed [CW-1:0] pos_x;
      logic signed [CW-1:0] pos_y;
      logic [NRM_W-1:0]     a;
      logic [NRM_W-1:0]     b;
   } side_type;

endpackage

### hw/rtl/oqv_norm.sv
// ---------------------------------------------------------------------------
// oqv_norm: front end
// magnitudes, half extents, joint normalization and sum of squares
// ---------------------------------------------------------------------------
module oqv_norm import oqv_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  req_type             in_item,
   input  logic [RATIO_W-1:0]  half_len_ratio,
   input  logic [RATIO_W-1:0]  half_wid_ratio,
   output logic                out_valid,
   output logic [2*NRM_W:0]    out_n,
   output side_type            out_side
);

   // stage 1
   logic                    s1_vld_ff;
   logic [CW-1:0]           s1_a_ff, s1_b_ff;
   logic                    s1_negx_ff, s1_posy_ff;
   logic signed [CW-1:0]    s1_px_ff, s1_py_ff;
   logic [RAD_W+RATIO_W-1:0] s1_pl_ff, s1_pw_ff;
   // stage 2
   logic                    s2_vld_ff;
   logic [CW-1:0]           s2_a_ff, s2_b_ff;
   logic                    s2_rsh_ff, s2_zero_ff;
   logic [4:0]              s2_lsh_ff;
   side_type                s2_side_ff;
   // stage 3
   logic                    s3_vld_ff;
   side_type                s3_side_ff;
   side_type                s3_side_in;
   // stage 4
   logic                    s4_vld_ff;
   logic [2*NRM_W-1:0]      s4_sqa_ff, s4_sqb_ff;
   side_type                s4_side_ff;
   // stage 5
   logic                    s5_vld_ff;
   logic [2*NRM_W:0]        s5_n_ff;
   side_type                s5_side_ff;

   logic [CW-1:0]           big_w;
   logic [4:0]              msb_w;
   logic [NRM_W-1:0]        a3_in, b3_in;
   logic [CW-1:0]           a_shl_w, b_shl_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
      end
   end

   // absolute values, extent products
   always_ff @(posedge clock) begin
      s1_a_ff    <= in_item.vel_x[CW-1] ? (CW'(0) - in_item.vel_x) : in_item.vel_x;
      s1_b_ff    <= in_item.vel_y[CW-1] ? (CW'(0) - in_item.vel_y) : in_item.vel_y;
      s1_negx_ff <= in_item.vel_x[CW-1];
      s1_posy_ff <= !in_item.vel_y[CW-1] && (in_item.vel_y != '0);
      s1_px_ff   <= in_item.pos_x;
      s1_py_ff   <= in_item.pos_y;
      s1_pl_ff   <= in_item.radius * half_len_ratio;
      s1_pw_ff   <= in_item.radius * half_wid_ratio;
   end

   // leading one of the larger magnitude
   always_comb begin
      big_w = (s1_a_ff > s1_b_ff) ? s1_a_ff : s1_b_ff;
      msb_w = '0;
      for (int i = 0; i < CW; i++) begin
         if (big_w[i]) msb_w = 5'(i);
      end
   end

   always_ff @(posedge clock) begin
      s2_a_ff          <= s1_a_ff;
      s2_b_ff          <= s1_b_ff;
      s2_rsh_ff        <= big_w[CW-1];
      s2_zero_ff       <= (big_w == '0);
      s2_lsh_ff        <= 5'(NRM_W - 1) - msb_w;
      s2_side_ff.neg_vx <= s1_negx_ff;
      s2_side_ff.pos_vy <= s1_posy_ff;
      s2_side_ff.zero  <= (big_w == '0);
      s2_side_ff.hl    <= RAD_W'((s1_pl_ff + (RAD_W+RATIO_W)'(16'h8000)) >> RATIO_W);
      s2_side_ff.hw    <= RAD_W'((s1_pw_ff + (RAD_W+RATIO_W)'(16'h8000)) >> RATIO_W);
      s2_side_ff.pos_x <= s1_px_ff;
      s2_side_ff.pos_y <= s1_py_ff;
      s2_side_ff.a     <= '0;
      s2_side_ff.b     <= '0;
   end

   // shift both by the same amount so the larger lies in [2^30, 2^31)
   always_comb begin
      a_shl_w = s2_a_ff << s2_lsh_ff;
      b_shl_w = s2_b_ff << s2_lsh_ff;
      if (s2_zero_ff) begin
         a3_in = '0;
         b3_in = '0;
      end else if (s2_rsh_ff) begin
         a3_in = s2_a_ff[CW-1:1];
         b3_in = s2_b_ff[CW-1:1];
      end else begin
         a3_in = a_shl_w[NRM_W-1:0];
         b3_in = b_shl_w[NRM_W-1:0];
      end
      s3_side_in   = s2_side_ff;
      s3_side_in.a = a3_in;
      s3_side_in.b = b3_in;
   end

   always_ff @(posedge clock) begin
      s3_side_ff   <= s3_side_in;
      s4_sqa_ff    <= s3_side_ff.a * s3_side_ff.a;
      s4_sqb_ff    <= s3_side_ff.b * s3_side_ff.b;
      s4_side_ff   <= s3_side_ff;
      s5_n_ff      <= {1'b0, s4_sqa_ff} + {1'b0, s4_sqb_ff};
      s5_side_ff   <= s4_side_ff;
   end

   assign out_valid = s5_vld_ff;
   assign out_n     = s5_n_ff;
   assign out_side  = s5_side_ff;

endmodule

### hw/rtl/oqv_sqrt.sv
// ---------------------------------------------------------------------------
// oqv_sqrt: pipelined integer square root
// one root bit per stage, floor of the square root of the sum of squares
// ---------------------------------------------------------------------------
module oqv_sqrt import oqv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [2*NRM_W:0]   in_n,
   input  side_type           in_side,
   output logic               out_valid,
   output logic [ROOT_W-1:0]  out_root,
   output side_type           out_side
);

   logic                vld_ff  [0:ROOT_W];
   logic [63:0]         rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0]   root_ff [0:ROOT_W];
   side_type            side_ff [0:ROOT_W];

   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else vld_ff[0] <= in_valid;
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= {1'b0, in_n};
      root_ff[0] <= '0;
      side_ff[0] <= in_side;
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
      localparam int I = ROOT_W - 1 - k;
      logic [63:0] trial_w;
      logic        take_w;

      // (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i)
      assign trial_w = ({32'd0, root_ff[k]} << (I + 1)) | (64'd1 << (2 * I));
      assign take_w  = rem_ff[k] >= trial_w;

      always_ff @(posedge clock) begin
         if (reset) vld_ff[k+1] <= 1'b0;
         else vld_ff[k+1] <= vld_ff[k];
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= take_w ? (rem_ff[k] - trial_w) : rem_ff[k];
         root_ff[k+1] <= take_w ? (root_ff[k] | (ROOT_W'(1) << I)) : root_ff[k];
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign out_valid = vld_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_side  = side_ff[ROOT_W];

endmodule

### hw/rtl/oqv_div.sv
// ---------------------------------------------------------------------------
// oqv_div: pipelined direction divider
// two restoring dividers give rounded cosine and sine in Q2.30
// ---------------------------------------------------------------------------
module oqv_div import oqv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [ROOT_W-1:0]  in_root,
   input  side_type           in_side,
   output logic               out_valid,
   output logic signed [CW-1:0] out_dc,
   output logic signed [CW-1:0] out_ds,
   output side_type           out_side
);

   logic                vld_ff  [0:QUO_W];
   logic [63:0]         remc_ff [0:QUO_W];
   logic [63:0]         rems_ff [0:QUO_W];
   logic [QUO_W-1:0]    qc_ff   [0:QUO_W];
   logic [QUO_W-1:0]    qs_ff   [0:QUO_W];
   logic [ROOT_W-1:0]   m_ff    [0:QUO_W];
   side_type            side_ff [0:QUO_W];

   logic                out_vld_ff;
   logic signed [CW-1:0] dc_ff, ds_ff;
   side_type            out_side_ff;

   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else vld_ff[0] <= in_valid;
   end

   // dividends with half the divisor added for rounding
   always_ff @(posedge clock) begin
      remc_ff[0] <= ({33'd0, in_side.a} << CS) + {33'd0, in_root[ROOT_W-1:1]};
      rems_ff[0] <= ({33'd0, in_side.b} << CS) + {33'd0, in_root[ROOT_W-1:1]};
      qc_ff[0]   <= '0;
      qs_ff[0]   <= '0;
      m_ff[0]    <= in_root;
      side_ff[0] <= in_side;
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_bit
      localparam int I = QUO_W - 1 - k;
      logic [63:0] dsor_w;
      logic        takec_w, takes_w;

      assign dsor_w  = {32'd0, m_ff[k]} << I;
      assign takec_w = remc_ff[k] >= dsor_w;
      assign takes_w = rems_ff[k] >= dsor_w;

      always_ff @(posedge clock) begin
         if (reset) vld_ff[k+1] <= 1'b0;
         else vld_ff[k+1] <= vld_ff[k];
      end

      always_ff @(posedge clock) begin
         remc_ff[k+1] <= takec_w ? (remc_ff[k] - dsor_w) : remc_ff[k];
         rems_ff[k+1] <= takes_w ? (rems_ff[k] - dsor_w) : rems_ff[k];
         qc_ff[k+1]   <= takec_w ? (qc_ff[k] | (QUO_W'(1) << I)) : qc_ff[k];
         qs_ff[k+1]   <= takes_w ? (qs_ff[k] | (QUO_W'(1) << I)) : qs_ff[k];
         m_ff[k+1]    <= m_ff[k];
         side_ff[k+1] <= side_ff[k];
      end
   end

   // signs and the zero velocity case
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else out_vld_ff <= vld_ff[QUO_W];
   end

   always_ff @(posedge clock) begin
      out_side_ff <= side_ff[QUO_W];
      if (side_ff[QUO_W].zero) begin
         dc_ff <= CW'(1) <<< CS;
         ds_ff <= '0;
      end else begin
         dc_ff <= side_ff[QUO_W].neg_vx ? (CW'(0) - {1'b0, qc_ff[QUO_W]})
                                        : {1'b0, qc_ff[QUO_W]};
         ds_ff <= side_ff[QUO_W].pos_vy ? (CW'(0) - {1'b0, qs_ff[QUO_W]})
                                        : {1'b0, qs_ff[QUO_W]};
      end
   end

   assign out_valid = out_vld_ff;
   assign out_dc    = dc_ff;
   assign out_ds    = ds_ff;
   assign out_side  = out_side_ff;

endmodule

### hw/rtl/oqv_corner.sv
// ---------------------------------------------------------------------------
// oqv_corner: corner rotation and placement
// products, corner sums, rounding and saturated position add
// ---------------------------------------------------------------------------
module oqv_corner import oqv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [CW-1:0] in_dc,
   input  logic signed [CW-1:0] in_ds,
   input  side_type             in_side,
   output logic                 out_valid,
   output rsp_type              out_item
);

   localparam int TW = 64;
   localparam int VW = TW - CS;

   logic                 p_vld_ff, s_vld_ff, r_vld_ff, o_vld_ff;
   logic signed [TW-1:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [TW-1:0] t_ff [0:7];
   logic signed [VW-1:0] v_ff [0:7];
   logic signed [CW-1:0] px_ff [0:2];
   logic signed [CW-1:0] py_ff [0:2];
   rsp_type              item_ff;

   logic signed [CW-1:0] hl_s, hw_s;

   // round half away from zero by CS bits
   function automatic logic signed [VW-1:0] rnd(input logic signed [TW-1:0] t);
      logic signed [TW-1:0] u;
      begin
         u = t + (t[TW-1] ? ((TW'(1) <<< (CS - 1)) - TW'(1)) : (TW'(1) <<< (CS - 1)));
         return u[TW-1:CS];
      end
   endfunction

   function automatic logic signed [CW-1:0] sat_add(input logic signed [VW-1:0] v,
                                                    input logic signed [CW-1:0] p);
      logic signed [VW:0] s;
      logic signed [VW:0] hi, lo;
      begin
         hi = (VW+1)'((64'sd1 <<< (CW - 1)) - 64'sd1);
         lo = -hi - (VW+1)'(1);
         s  = $signed({v[VW-1], v}) + $signed({{(VW+1-CW){p[CW-1]}}, p});
         if (s > hi) return hi[CW-1:0];
         else if (s < lo) return lo[CW-1:0];
         else return s[CW-1:0];
      end
   endfunction

   assign hl_s = $signed({1'b0, in_side.hl});
   assign hw_s = $signed({1'b0, in_side.hw});

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
         s_vld_ff <= 1'b0;
         r_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= in_valid;
         s_vld_ff <= p_vld_ff;
         r_vld_ff <= s_vld_ff;
         o_vld_ff <= r_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff    <= in_dc * hl_s;
      p2_ff    <= in_ds * hw_s;
      p3_ff    <= in_ds * hl_s;
      p4_ff    <= in_dc * hw_s;
      px_ff[0] <= in_side.pos_x;
      py_ff[0] <= in_side.pos_y;

      // x uses c*x + s*y, y uses -s*x + c*y
      t_ff[0]  <= p1_ff + p2_ff;
      t_ff[1]  <= p4_ff - p3_ff;
      t_ff[2]  <= p1_ff - p2_ff;
      t_ff[3]  <= -p3_ff - p4_ff;
      t_ff[4]  <= -p1_ff - p2_ff;
      t_ff[5]  <= p3_ff - p4_ff;
      t_ff[6]  <= p2_ff - p1_ff;
      t_ff[7]  <= p3_ff + p4_ff;
      px_ff[1] <= px_ff[0];
      py_ff[1] <= py_ff[0];

      for (int i = 0; i < 8; i++) begin
         v_ff[i] <= rnd(t_ff[i]);
      end
      px_ff[2] <= px_ff[1];
      py_ff[2] <= py_ff[1];

      item_ff.front_left_x  <= sat_add(v_ff[0], px_ff[2]);
      item_ff.front_left_y  <= sat_add(v_ff[1], py_ff[2]);
      item_ff.front_right_x <= sat_add(v_ff[2], px_ff[2]);
      item_ff.front_right_y <= sat_add(v_ff[3], py_ff[2]);
      item_ff.back_right_x  <= sat_add(v_ff[4], px_ff[2]);
      item_ff.back_right_y  <= sat_add(v_ff[5], py_ff[2]);
      item_ff.back_left_x   <= sat_add(v_ff[6], px_ff[2]);
      item_ff.back_left_y   <= sat_add(v_ff[7], py_ff[2]);
   end

   assign out_valid = o_vld_ff;
   assign out_item  = item_ff;

endmodule

### hw/rtl/oriented_quad_vertices.sv
// ---------------------------------------------------------------------------
// oriented_quad_vertices: corners of a travel-aligned thin rectangle
// start to rsp_strobe: front end, root, divider, corners; one transaction per cycle
// outside reset, set by a fully pipelined root (one bit per stage) and divider
// reset is synchronous: clears all valid bits and reloads both ratio registers
// busy is high only during reset; the receiver cannot stall, nothing backs up
// ---------------------------------------------------------------------------
`include "oriented_quad_vertices_defines.svh"

module oriented_quad_vertices import oqv_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_item,
   // result channel, one-cycle strobe
   output logic                  rsp_strobe,
   output rsp_type               rsp_item,
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [RATIO_W-1:0]    csr_wdata
);

   logic [RATIO_W-1:0] half_len_ff, half_wid_ff;
   logic               accept;

   // front end to root
   logic               nrm_valid;
   logic [2*NRM_W:0]   nrm_n;
   side_type           nrm_side;
   // root to divider
   logic               sq_valid;
   logic [ROOT_W-1:0]  sq_root;
   side_type           sq_side;
   // divider to corners
   logic               dv_valid;
   logic signed [CW-1:0] dv_dc, dv_ds;
   side_type           dv_side;

   // no stall path: outside reset the pipeline takes a transaction every cycle
   assign busy   = reset;
   assign accept = start && !busy;

   // configuration registers, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         half_len_ff <= HALF_LENGTH_RESET;
         half_wid_ff <= HALF_WIDTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_HALF_LENGTH: half_len_ff <= csr_wdata;
            REG_HALF_WIDTH:  half_wid_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // magnitudes, half extents, normalization, squares
   oqv_norm u_norm (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (accept),
      .in_item        (req_item),
      .half_len_ratio (half_len_ff),
      .half_wid_ratio (half_wid_ff),
      .out_valid      (nrm_valid),
      .out_n          (nrm_n),
      .out_side       (nrm_side)
   );

   // |v| of the normalized vector
   oqv_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (nrm_valid),
      .in_n      (nrm_n),
      .in_side   (nrm_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // cosine and sine
   oqv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_dc    (dv_dc),
      .out_ds    (dv_ds),
      .out_side  (dv_side)
   );

   // rotate, round, place and saturate the four corners
   oqv_corner u_corner (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid),
      .in_dc     (dv_dc),
      .in_ds     (dv_ds),
      .in_side   (dv_side),
      .out_valid (rsp_strobe),
      .out_item  (rsp_item)
   );

   // every result traces back to an earlier accepted transaction
   `OQV_ASSERT_IMPLY(a_rsp_latency, clock, reset, rsp_strobe, $past(accept, LATENCY))
   // a write to the length ratio lands on the next cycle
   `OQV_ASSERT_NEXT(a_len_write, clock, reset, csr_we && (csr_index == REG_HALF_LENGTH), half_len_ff == $past(csr_wdata))
   // divider output of a stopped body is the identity rotation
   `OQV_ASSERT_IMPLY(a_zero_dir, clock, reset, dv_valid && dv_side.zero, (dv_ds == '0) && (dv_dc == (CW'(1) <<< CS)))

endmodule

### sim/oqv_checker.sv
// ---------------------------------------------------------------------------
// oqv_checker: corner prediction and result comparison
// watches accepted requests, computes the four expected corners, compares
// ---------------------------------------------------------------------------
module oqv_checker import oqv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  req_type            req_item,
   input  logic               rsp_strobe,
   input  rsp_type            rsp_item,
   input  logic               csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RATIO_W-1:0] csr_wdata,
   output int                 fail_count,
   output int                 pending
);

   logic [RATIO_W-1:0] length_ratio, width_ratio;
   rsp_type corner_queue[$];

   function automatic logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [CW-1:0] place_corner(
      longint ca, longint xa, longint cb, longint xb, longint p);
      longint t, v;
      logic [63:0] m, r;
      t = ca * xa + cb * xb;
      m = (t < 0) ? -t : t;
      r = (m + (64'd1 << (CS - 1))) >> CS;
      v = (t < 0) ? -longint'(r) : longint'(r);
      v += p;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[CW-1:0];
   endfunction

   function automatic rsp_type predict_corners(req_type rq);
      longint vx, vy, hl, hw, dc, ds;
      logic [63:0] a, b, big, m, cm, sm, rad;
      longint lx[4], ly[4];
      logic signed [CW-1:0] cxy[8];
      rsp_type res;
      vx = rq.vel_x;
      vy = rq.vel_y;
      rad = rq.radius;
      hl = (rad * length_ratio + 64'h8000) >> 16;
      hw = (rad * width_ratio + 64'h8000) >> 16;
      a = (vx < 0) ? -vx : vx;
      b = (vy < 0) ? -vy : vy;
      big = (a > b) ? a : b;
      if (big == 0) begin
         dc = 64'sd1 << CS;
         ds = 0;
      end else begin
         while (big >= (64'd1 << 31)) begin
            a >>= 1; b >>= 1; big >>= 1;
         end
         while (big < (64'd1 << 30)) begin
            a <<= 1; b <<= 1; big <<= 1;
         end
         m = root_floor(a * a + b * b);
         cm = ((a << CS) + (m >> 1)) / m;
         sm = ((b << CS) + (m >> 1)) / m;
         dc = (vx < 0) ? -longint'(cm) : longint'(cm);
         ds = (vy > 0) ? -longint'(sm) : longint'(sm);
      end
      lx = '{hl, hl, -hl, -hl};
      ly = '{hw, -hw, -hw, hw};
      for (int k = 0; k < 4; k++) begin
         cxy[2*k]   = place_corner(dc, lx[k], ds, ly[k], longint'(rq.pos_x));
         cxy[2*k+1] = place_corner(-ds, lx[k], dc, ly[k], longint'(rq.pos_y));
      end
      res.front_left_x  = cxy[0]; res.front_left_y  = cxy[1];
      res.front_right_x = cxy[2]; res.front_right_y = cxy[3];
      res.back_right_x  = cxy[4]; res.back_right_y  = cxy[5];
      res.back_left_x   = cxy[6]; res.back_left_y   = cxy[7];
      return res;
   endfunction

   task automatic check_field(string name, logic [CW-1:0] exp_v, logic [CW-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %h actual %h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         length_ratio <= HALF_LENGTH_RESET;
         width_ratio  <= HALF_WIDTH_RESET;
      end else begin
         if (start && !busy) corner_queue.push_back(predict_corners(req_item));
         if (rsp_strobe) begin
            if (corner_queue.size() == 0) begin
               $error("result transaction with no expectation");
               fail_count++;
            end else begin
               exp_r = corner_queue.pop_front();
               check_field("front_left_x", exp_r.front_left_x, rsp_item.front_left_x);
               check_field("front_left_y", exp_r.front_left_y, rsp_item.front_left_y);
               check_field("front_right_x", exp_r.front_right_x, rsp_item.front_right_x);
               check_field("front_right_y", exp_r.front_right_y, rsp_item.front_right_y);
               check_field("back_right_x", exp_r.back_right_x, rsp_item.back_right_x);
               check_field("back_right_y", exp_r.back_right_y, rsp_item.back_right_y);
               check_field("back_left_x", exp_r.back_left_x, rsp_item.back_left_x);
               check_field("back_left_y", exp_r.back_left_y, rsp_item.back_left_y);
            end
         end
         if (csr_we) begin
            if (csr_index == REG_HALF_LENGTH) length_ratio <= csr_wdata;
            else if (csr_index == REG_HALF_WIDTH) width_ratio <= csr_wdata;
         end
      end
      pending = corner_queue.size();
   end

endmodule

### sim/tb_oriented_quad_vertices.sv
// ---------------------------------------------------------------------------
// tb_oriented_quad_vertices: quad corner testbench top
// drives directed and random transactions over several ratio settings;
// the checker predicts and compares every result
// ---------------------------------------------------------------------------
module tb_oriented_quad_vertices;
   import oqv_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   req_type req_item = '0;
   logic rsp_strobe;
   rsp_type rsp_item;
   logic csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [RATIO_W-1:0] csr_wdata = '0;
   int fail_count, pending;
   int cycle_count = 0;

   always #5 clock = ~clock;

   oriented_quad_vertices dut (.*);

   oqv_checker checker_i (.*);

   // run guard: ends a stuck run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // random 32-bit value, biased toward extremes and small magnitudes
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff - $urandom_range(0, 3);
         1: return 32'h80000000 + $urandom_range(0, 3);
         2: return $urandom_range(0, 15) - 8;
         3: return $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
         default: return $urandom();
      endcase
   endfunction

   // send one transaction; start stays high into the next one when there is no gap
   task automatic send_request(req_type rq, bit allow_gap);
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_item <= rq;
      start <= 1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // both ratio registers, one write per cycle
   task automatic write_ratios(logic [RATIO_W-1:0] len_val, logic [RATIO_W-1:0] wid_val);
      csr_we <= 1;
      csr_index <= REG_HALF_LENGTH;
      csr_wdata <= len_val;
      @(negedge clock);
      csr_index <= REG_HALF_WIDTH;
      csr_wdata <= wid_val;
      @(negedge clock);
      csr_we <= 0;
   endtask

   // settle: every expected result back, then pipeline drains
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   function automatic req_type random_request();
      req_type rq;
      rq.vel_x = pick_coord();
      rq.vel_y = pick_coord();
      rq.pos_x = pick_coord();
      rq.pos_y = pick_coord();
      rq.radius = RAD_W'(pick_coord());
      return rq;
   endfunction

   initial begin
      req_type rq;
      logic [RATIO_W-1:0] len_set[4];
      logic [RATIO_W-1:0] wid_set[4];
      len_set = '{16'd0, 16'hffff, 16'd58982, 16'd30000};
      wid_set = '{16'hffff, 16'd0, 16'd6554, 16'd12345};
      repeat (12) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      while (busy) @(negedge clock);

      // directed: zero velocity, axis directions, extremes, saturation, zero radius, then random fill
      for (int k = 0; k < 20; k++) begin
         rq = '0;
         rq.radius = 31'h10000;
         case (k)
            0: ;
            1: rq.vel_x = 32'sh10000;
            2: rq.vel_x = -32'sh10000;
            3: rq.vel_y = 32'sh10000;
            4: rq.vel_y = -32'sh10000;
            5: begin rq.vel_x = 32'sh7fffffff; rq.vel_y = 32'sh7fffffff; end
            6: begin rq.vel_x = 32'sh80000000; rq.vel_y = 32'sh80000000; end
            7: begin rq.vel_x = 1; rq.vel_y = -1; end
            8: begin rq.vel_x = 32'sh80000000; rq.radius = '1; end
            9: begin rq.pos_x = 32'sh7fffffff; rq.pos_y = 32'sh7fffffff;
                      rq.radius = '1; rq.vel_x = 3; end
            10: begin rq.pos_x = 32'sh80000000; rq.pos_y = 32'sh80000000;
                      rq.radius = '1; rq.vel_y = -5; end
            11: rq.radius = '0;
            12: begin rq.vel_x = 32'sh30000; rq.vel_y = 32'sh40000; end
            13: begin rq.vel_x = -1; rq.vel_y = 32'sh7fffffff; rq.radius = '1; end
            default: rq = random_request();
         endcase
         send_request(rq, 0);
      end
      start <= 0;
      drain();

      // random phases across ratio settings, extremes included
      for (int ph = 0; ph < 5; ph++) begin
         if (ph < 4) begin
            write_ratios(len_set[ph], wid_set[ph]);
         end else begin
            write_ratios(RATIO_W'($urandom()), RATIO_W'($urandom()));
         end
         for (int n = 0; n < 190; n++)
            send_request(random_request(), ph < 4);
         start <= 0;
         drain();
      end

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
